// File: sv/geo_pkg.sv
// Package for the geohash encoder: widths, limits, initial bisection
// intervals, the job record and the base-32 character table. No dependencies.
package geo_pkg;

  localparam int unsigned MAX_CHARS       = 32;
  localparam int unsigned EXTRA_FRAC_BITS = 32;

  localparam int unsigned LAT_W  = 31;
  localparam int unsigned LON_W  = 32;
  localparam int unsigned PREC_W = 6;
  localparam int unsigned CHAR_W = 7;

  // Endpoints carry the extra fraction bits; span width leaves out the sign.
  localparam int unsigned LAT_EP_W   = LAT_W + EXTRA_FRAC_BITS;
  localparam int unsigned LON_EP_W   = LON_W + EXTRA_FRAC_BITS;
  localparam int unsigned LAT_SPAN_W = LAT_EP_W - 1;
  localparam int unsigned LON_SPAN_W = LON_EP_W - 1;

  localparam longint LAT_LIMIT_VAL = 64'sd377487360;  // 90 deg at 2^-22
  localparam longint LON_LIMIT_VAL = 64'sd754974720;  // 180 deg at 2^-22

  localparam logic signed [LAT_W-1:0] LAT_LIMIT = LAT_W'(LAT_LIMIT_VAL);
  localparam logic signed [LON_W-1:0] LON_LIMIT = LON_W'(LON_LIMIT_VAL);

  localparam logic signed [LAT_EP_W-1:0] LAT_LO_INIT =
    LAT_EP_W'(-LAT_LIMIT_VAL) <<< EXTRA_FRAC_BITS;
  localparam logic signed [LON_EP_W-1:0] LON_LO_INIT =
    LON_EP_W'(-LON_LIMIT_VAL) <<< EXTRA_FRAC_BITS;
  localparam logic [LAT_SPAN_W-1:0] LAT_SPAN_INIT =
    LAT_SPAN_W'(2 * LAT_LIMIT_VAL) << EXTRA_FRAC_BITS;
  localparam logic [LON_SPAN_W-1:0] LON_SPAN_INIT =
    LON_SPAN_W'(2 * LON_LIMIT_VAL) << EXTRA_FRAC_BITS;

  localparam int unsigned BITS_PER_CHAR = 5;
  localparam int unsigned ACC_W         = 4;   // leftover bits between steps
  localparam int unsigned CNT_W         = 3;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                     err;
    logic signed [LAT_W-1:0]  lat;
    logic signed [LON_W-1:0]  lon;
    logic [PREC_W-1:0]        prec;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  localparam logic [CHAR_W-1:0] CODE_TABLE [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h6A, 7'h6B, 7'h6D, 7'h6E, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A
  };

  function automatic logic [CHAR_W-1:0] code_char(input logic [BITS_PER_CHAR-1:0] idx);
    return CODE_TABLE[idx];
  endfunction

endpackage

// File: sv/geo_req_if.sv
// Request channel of the geohash encoder: valid/ready plus coordinates
// and precision. Depends on geo_pkg.
interface geo_req_if;
  import geo_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic [PREC_W-1:0]       precision;

  modport source (output valid, latitude, longitude, precision, input ready);
  modport sink   (input valid, latitude, longitude, precision, output ready);
endinterface

// File: sv/geo_rsp_if.sv
// Result channel of the geohash encoder: valid/ready plus one character,
// last and error flags. Depends on geo_pkg.
interface geo_rsp_if;
  import geo_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  logic              error;

  modport source (output valid, char_code, last, error, input ready);
  modport sink   (input valid, char_code, last, error, output ready);
endinterface

// File: sv/geo_front.sv
// Front end: takes request transfers, range-checks precision and
// coordinates, and pushes a job record into the queue. Depends on geo_pkg.
module geo_front import geo_pkg::*; (
  geo_req_if.sink req_i,
  input  logic    full_i,
  output logic    push_o,
  output job_t    job_o
);

  logic lat_ok, lon_ok, prec_ok;

  assign lat_ok  = (req_i.latitude >= -LAT_LIMIT) && (req_i.latitude <= LAT_LIMIT);
  assign lon_ok  = (req_i.longitude >= -LON_LIMIT) && (req_i.longitude <= LON_LIMIT);
  assign prec_ok = (req_i.precision != '0) &&
                   (req_i.precision <= PREC_W'(MAX_CHARS));

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  always_comb begin
    job_o.err  = !(lat_ok && lon_ok && prec_ok);
    job_o.lat  = req_i.latitude;
    job_o.lon  = req_i.longitude;
    job_o.prec = req_i.precision;
  end

endmodule

// File: sv/geo_fifo.sv
// Short job queue between front end and bisection back end.
// Depends on geo_pkg (job_t, FIFO_DEPTH).
module geo_fifo import geo_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/geo_back.sv
// Back end: bisects longitude and latitude one step each per cycle unless the
// result register is held, packs bits into characters and drives it. Depends on geo_pkg.
module geo_back import geo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_vld_i,
  output logic      job_pop_o,
  geo_rsp_if.source rsp_o
);

  back_state_e state_q, state_d;

  logic signed [LAT_EP_W-1:0] lat_c_q, lat_c_d, lat_lo_q, lat_lo_d, lat_mid;
  logic signed [LON_EP_W-1:0] lon_c_q, lon_c_d, lon_lo_q, lon_lo_d, lon_mid;
  logic [LAT_SPAN_W-1:0]      lat_w_q, lat_w_d, lat_half;
  logic [LON_SPAN_W-1:0]      lon_w_q, lon_w_d, lon_half;
  logic                       lat_bit, lon_bit;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PREC_W-1:0] done_q, done_d, prec_q, prec_d;
  logic [ACC_W+1:0]  acc_new;

  logic              out_vld_q, out_vld_d, out_last_q, out_last_d, out_err_q, out_err_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_free;

  // One bisection step per axis; span is carried instead of the upper end.
  assign lat_half = lat_w_q >> 1;
  assign lon_half = lon_w_q >> 1;
  assign lat_mid  = lat_lo_q + $signed({1'b0, lat_half});
  assign lon_mid  = lon_lo_q + $signed({1'b0, lon_half});
  assign lat_bit  = lat_c_q > lat_mid;
  assign lon_bit  = lon_c_q > lon_mid;
  assign acc_new  = {acc_q, lon_bit, lat_bit};

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign job_pop_o = (state_q == BK_IDLE) && job_vld_i && out_free;

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.char_code = out_char_q;
  assign rsp_o.last      = out_last_q;
  assign rsp_o.error     = out_err_q;

  always_comb begin
    state_d    = state_q;
    lat_c_d    = lat_c_q;
    lon_c_d    = lon_c_q;
    lat_lo_d   = lat_lo_q;
    lon_lo_d   = lon_lo_q;
    lat_w_d    = lat_w_q;
    lon_w_d    = lon_w_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    done_d     = done_q;
    prec_d     = prec_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    out_err_d  = out_err_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_pop_o) begin
          if (job_i.err) begin
            out_vld_d  = 1'b1;
            out_char_d = '0;
            out_last_d = 1'b1;
            out_err_d  = 1'b1;
          end else begin
            lat_c_d  = LAT_EP_W'(job_i.lat) <<< EXTRA_FRAC_BITS;
            lon_c_d  = LON_EP_W'(job_i.lon) <<< EXTRA_FRAC_BITS;
            lat_lo_d = LAT_LO_INIT;
            lon_lo_d = LON_LO_INIT;
            lat_w_d  = LAT_SPAN_INIT;
            lon_w_d  = LON_SPAN_INIT;
            acc_d    = '0;
            cnt_d    = '0;
            done_d   = '0;
            prec_d   = job_i.prec;
            state_d  = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        if (out_free) begin
          lat_lo_d = lat_bit ? lat_mid : lat_lo_q;
          lat_w_d  = lat_bit ? (lat_w_q - lat_half) : lat_half;
          lon_lo_d = lon_bit ? lon_mid : lon_lo_q;
          lon_w_d  = lon_bit ? (lon_w_q - lon_half) : lon_half;
          // Two new bits per step; a character completes at five or six held bits.
          if (cnt_q == CNT_W'(BITS_PER_CHAR - 2)) begin
            out_char_d = code_char(acc_new[BITS_PER_CHAR-1:0]);
            acc_d      = '0;
            cnt_d      = '0;
          end else if (cnt_q == CNT_W'(BITS_PER_CHAR - 1)) begin
            out_char_d = code_char(acc_new[BITS_PER_CHAR:1]);
            acc_d      = ACC_W'(acc_new[0]);
            cnt_d      = CNT_W'(1);
          end else begin
            acc_d = acc_new[ACC_W-1:0];
            cnt_d = cnt_q + CNT_W'(2);
          end
          if (cnt_q >= CNT_W'(BITS_PER_CHAR - 2)) begin
            out_vld_d  = 1'b1;
            out_err_d  = 1'b0;
            out_last_d = (done_q + 1'b1 == prec_q);
            done_d     = done_q + 1'b1;
            if (done_q + 1'b1 == prec_q) begin
              state_d = BK_IDLE;
            end
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      cnt_q     <= '0;
      done_q    <= '0;
      prec_q    <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      prec_q    <= prec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lat_c_q    <= lat_c_d;
    lon_c_q    <= lon_c_d;
    lat_lo_q   <= lat_lo_d;
    lon_lo_q   <= lon_lo_d;
    lat_w_q    <= lat_w_d;
    lon_w_q    <= lon_w_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN) |-> (cnt_q <= CNT_W'(BITS_PER_CHAR - 1)))
    else $error("bit count out of range");

  a_done_below_prec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN) |-> (done_q < prec_q))
    else $error("character count passed precision while running");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_err_q) |-> (out_last_q && out_char_q == '0))
    else $error("error result not a single zero last item");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> (state_q == BK_IDLE && out_free))
    else $error("job taken while busy");

endmodule

// File: sv/geohash_encoder_core.sv
// Top level of the geohash encoder: front end, job queue and bisection
// back end. Depends on geo_pkg, geo_req_if, geo_rsp_if, geo_front, geo_fifo, geo_back.
//
// Encodes a latitude/longitude (units of 2^-22 degree) into 1 to 32 base-32
// geohash characters, one result transfer per character, the final one
// flagged last. A bad precision or an out-of-range coordinate yields a single
// result with char_code 0, last and error set. The front end checks each
// request and pushes it into a two-entry queue in the cycle of the transfer,
// so up to two requests can be taken while the back end works. The back end
// loads a job, then does one longitude and one latitude bisection step per
// cycle unless held (a 64-bit add and compare for longitude, 63-bit for
// latitude); an error request never leaves the idle state. Results leave
// through an output register, and the back end holds while that register
// is full and not taken. Interval endpoints carry 32 extra fraction bits;
// midpoints are exact through 22 characters and rounded toward minus
// infinity beyond.
module geohash_encoder_core import geo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  geo_req_if.sink   req_i,
  geo_rsp_if.source rsp_o
);

  job_t push_job, pop_job;
  logic push, full, pop, empty;

  // Classify and enqueue each request transfer.
  geo_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  // Decouples request acceptance from character generation.
  geo_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  // Bisection datapath and result register.
  geo_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (pop_job),
    .job_vld_i (!empty),
    .job_pop_o (pop),
    .rsp_o     (rsp_o)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for geohash_encoder_core: random and directed requests against a
// bisection predictor, result transfers checked in order.
// Depends on geo_pkg, geo_req_if, geo_rsp_if and the encoder RTL.
module tb_top;
  import geo_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;    // long receiver stall
  localparam int unsigned RUN_LIMIT    = 400000; // timeout in cycles
  localparam int unsigned RANDOM_ITEMS = 150;

  // Predicts the character stream of each request and checks results
  // against it in arrival order.
  class geohash_scoreboard;
    typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
      logic              error;
    } geo_char_t;

    geo_char_t   expected_chars[$];
    int unsigned mismatch_count;
    string       alphabet;

    function new();
      alphabet       = "0123456789bcdefghjkmnpqrstuvwxyz";
      mismatch_count = 0;
    endfunction

    // Bisect longitude and latitude in turn, endpoints in offset binary
    // with the extra fraction bits, five bits per character, MSB first.
    function void encode_request(input logic signed [LAT_W-1:0]  lat,
                                 input logic signed [LON_W-1:0]  lon,
                                 input logic        [PREC_W-1:0] prec);
      longint      lat_v, lon_v;
      logic [63:0] lo [2];
      logic [63:0] hi [2];
      logic [63:0] crd [2];
      logic [63:0] mid;
      logic [4:0]  idx;
      int          ax, p;
      lat_v = lat;
      lon_v = lon;
      p     = int'(prec);
      if (p == 0 || p > int'(MAX_CHARS) ||
          lat_v < -LAT_LIMIT_VAL || lat_v > LAT_LIMIT_VAL ||
          lon_v < -LON_LIMIT_VAL || lon_v > LON_LIMIT_VAL) begin
        expected_chars.push_back('{char_code: '0, last: 1'b1, error: 1'b1});
        return;
      end
      // index 0 is latitude, 1 is longitude
      lo[0]  = (64'(-LAT_LIMIT_VAL) << EXTRA_FRAC_BITS) ^ 64'h8000_0000_0000_0000;
      hi[0]  = (64'(LAT_LIMIT_VAL) << EXTRA_FRAC_BITS) ^ 64'h8000_0000_0000_0000;
      lo[1]  = (64'(-LON_LIMIT_VAL) << EXTRA_FRAC_BITS) ^ 64'h8000_0000_0000_0000;
      hi[1]  = (64'(LON_LIMIT_VAL) << EXTRA_FRAC_BITS) ^ 64'h8000_0000_0000_0000;
      crd[0] = (64'(lat_v) << EXTRA_FRAC_BITS) ^ 64'h8000_0000_0000_0000;
      crd[1] = (64'(lon_v) << EXTRA_FRAC_BITS) ^ 64'h8000_0000_0000_0000;
      ax     = 1;
      for (int n = 0; n < p; n++) begin
        idx = '0;
        for (int b = 0; b < 5; b++) begin
          mid = lo[ax] + ((hi[ax] - lo[ax]) >> 1);
          // equal to the midpoint goes to the lower half
          if (crd[ax] > mid) begin
            lo[ax]   = mid;
            idx[4-b] = 1'b1;
          end else begin
            hi[ax] = mid;
          end
          ax = 1 - ax;
        end
        expected_chars.push_back('{char_code: CHAR_W'(alphabet.getc(int'(idx))),
                                   last: (n == p - 1), error: 1'b0});
      end
    endfunction

    task report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_char(input logic [CHAR_W-1:0] code, input logic last, input logic error);
      geo_char_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("result char %0h last %b error %b with nothing pending",
                                  code, last, error));
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.char_code)
        report_mismatch($sformatf("char_code %0h, wanted %0h", code, want.char_code));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, wanted %b", last, want.last));
      if (error !== want.error)
        report_mismatch($sformatf("error %b, wanted %b", error, want.error));
    endtask
  endclass

  bit          clk;
  logic        rst_n;
  logic        idle_on;      // random idling on both sides
  int unsigned hold_ask;     // bumped to request one long receiver stall
  int unsigned cycle_count = 0;

  geohash_scoreboard sb;

  geo_req_if req_if ();
  geo_rsp_if rsp_if ();

  geohash_encoder_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout: a hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitors sample pre-edge values; all drivers use nonblocking updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready)
        sb.encode_request(req_if.latitude, req_if.longitude, req_if.precision);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_char(rsp_if.char_code, rsp_if.last, rsp_if.error);
    end
  end

  // Receiver: random ready, or a long stall when the stimulus asks for one.
  // The stall is counted here so the sender keeps offering meanwhile.
  initial begin
    int unsigned hold_seen;
    hold_seen    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_if.ready <= !(idle_on && $urandom_range(99) < 37);
      end
    end
  end

  // Offer one request, idling at random first, and wait for its transfer.
  task automatic send_req(input longint lat, input longint lon, input int prec);
    while (idle_on && $urandom_range(99) < 37) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.latitude  <= LAT_W'(lat);
    req_if.longitude <= LON_W'(lon);
    req_if.precision <= PREC_W'(prec);
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_results_done();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    longint lat, lon;
    int     prec, pick, steps;
    sb               = new();
    rst_n            = 1'b0;
    idle_on          = 1'b1;
    hold_ask         = 0;
    req_if.valid     = 1'b0;
    req_if.latitude  = '0;
    req_if.longitude = '0;
    req_if.precision = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners, midpoint ties, precision limits, every error cause.
    send_req(0, 0, 1);                              // both on the first midpoint
    send_req(0, 0, 2);
    send_req(LAT_LIMIT_VAL, LON_LIMIT_VAL, 12);     // north-east corner
    send_req(-LAT_LIMIT_VAL, -LON_LIMIT_VAL, 12);   // south-west corner
    send_req(LAT_LIMIT_VAL, -LON_LIMIT_VAL, 32);
    send_req(-LAT_LIMIT_VAL, LON_LIMIT_VAL, 32);
    send_req(0, 0, 32);
    send_req(LAT_LIMIT_VAL / 2, LON_LIMIT_VAL / 2, 6);  // second-step ties
    send_req(1, -1, 32);                            // one LSB off the center
    send_req(123456789, -543210987, 13);            // arbitrary point, midpoints still exact
    send_req(-300000000, 700000000, 31);
    send_req(0, 0, 0);                              // bad precision
    send_req(0, 0, 33);
    send_req(0, 0, 63);
    send_req(LAT_LIMIT_VAL + 1, 0, 4);              // just off each range
    send_req(-LAT_LIMIT_VAL - 1, 0, 4);
    send_req(0, LON_LIMIT_VAL + 1, 4);
    send_req(0, -LON_LIMIT_VAL - 1, 4);
    send_req(-1073741824, -64'sd2147483648, 5);     // field minimum
    send_req(1073741823, 2147483647, 5);            // field maximum
    send_req(1073741823, 0, 63);                    // two causes at once
    wait_results_done();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on <= !(i >= 40 && i < 75);              // stretch with no idling
      if (i == 100)
        hold_ask <= hold_ask + 1;                   // fill the block, stall input
      if (i == 120)
        wait_results_done();

      pick = $urandom_range(99);
      prec = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, MAX_CHARS);
      lat  = longint'($urandom_range(2 * LAT_LIMIT_VAL)) - LAT_LIMIT_VAL;
      lon  = longint'($urandom_range(2 * LON_LIMIT_VAL)) - LON_LIMIT_VAL;
      if (pick < 15) begin
        // grid points land exactly on early midpoints
        steps = 1 << $urandom_range(1, 6);
        lat   = (longint'($urandom_range(2 * steps)) - steps) * (LAT_LIMIT_VAL / steps);
        steps = 1 << $urandom_range(1, 6);
        lon   = (longint'($urandom_range(2 * steps)) - steps) * (LON_LIMIT_VAL / steps);
      end else if (pick < 78) begin
        // plain in-range request
      end else if (pick < 86) begin
        prec = ($urandom_range(1) == 0) ? 0 : $urandom_range(33, 63);
      end else if (pick < 93) begin
        // raw field noise, mostly out of range
        lat  = $urandom();
        lon  = $urandom();
        prec = $urandom_range(0, 63);
      end else if ($urandom_range(1) == 0) begin
        lat = LAT_LIMIT_VAL + $urandom_range(1, 1000);
        if ($urandom_range(1) == 0) lat = -lat;
      end else begin
        lon = LON_LIMIT_VAL + $urandom_range(1, 1000);
        if ($urandom_range(1) == 0) lon = -lon;
      end
      send_req(lat, lon, prec);
    end

    wait_results_done();
    repeat (200) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_chars.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
